[rtl/msbp_pkg.sv]
package msbp_pkg;

  // Input word kinds, carried on the slave tuser
  typedef enum logic [1:0] {
    ModeBit    = 2'd0,
    ModeSymbol = 2'd1,
    ModeNumber = 2'd2,
    ModeFlush  = 2'd3
  } mode_e;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned ValueW     = 32;
  localparam int unsigned MaxBytes   = ValueW / ByteW;
  localparam int unsigned PendW      = 3;
  localparam int unsigned BitCntW    = 6;
  localparam int unsigned ByteIdxW   = 2;

  // One queued job: up to four finished bytes, emitted from index 0 up
  typedef struct packed {
    logic [MaxBytes-1:0][ByteW-1:0] bytes;
    logic [ByteIdxW-1:0]            last_idx;
  } job_t;

endpackage

[rtl/msb_first_bit_packer.sv]
// MSB-first bit packer.
// Slave channel: one word per item. s_axis_tuser_i selects the kind:
// one bit (tdata bit 0), an 8-bit symbol (tdata[7:0]), a 32-bit number
// (tdata[31:0]) or a flush. Bits fill each byte from bit 7 downward.
// Master channel: one packed byte per word; tlast marks the final byte
// that one input item produced. A flush sends the pending partial byte
// with zero low bits, or nothing when no bits are pending.
// A byte enters the job queue at the edge that accepts the item completing
// it; the output register loads it when empty or when its byte is taken.
// Throughput: one input item per cycle while the queue is not full and one
// output byte per cycle while the receiver is ready; a 32-bit number turns
// into up to four bytes that the output register sends one per cycle, so
// its job holds the back end until its last byte is loaded.
// When the receiver stalls, the output register holds its byte and the
// job queue (QUEUE_DEPTH jobs) absorbs items until full, then tready drops.
// Reset clears the partial byte, its bit count, the queue and the output.
module msb_first_bit_packer
  import msbp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [ValueW-1:0]  s_axis_tdata_i,   // [31:0] value
  input  logic [1:0]         s_axis_tuser_i,   // [1:0] mode
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [ByteW-1:0]   m_axis_tdata_o,   // [7:0] out_byte
  output logic               m_axis_tlast_o    // last
);

  logic accept;
  logic push;
  logic full;
  logic job_valid;
  logic pop;
  job_t job_in;
  job_t job_out;

  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Front: pack incoming bits into finished bytes
  msbp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .mode_i   (s_axis_tuser_i),
    .value_i  (s_axis_tdata_i),
    .push_o   (push),
    .job_o    (job_in)
  );

  // Queue of byte jobs between front and back
  msbp_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .valid_o (job_valid),
    .job_o   (job_out),
    .pop_i   (pop)
  );

  // Back: send each job's bytes one word at a time
  msbp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (job_valid),
    .job_i           (job_out),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

[rtl/msbp_front.sv]
module msbp_front
  import msbp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [1:0]          mode_i,
  input  logic [ValueW-1:0]   value_i,
  output logic                push_o,
  output job_t                job_o
);

  logic [ByteW-1:0]                partial_q, partial_d;
  logic [PendW-1:0]                pend_q, pend_d;
  logic [ValueW-1:0]               bits_lj;
  logic [BitCntW-1:0]              nbits;
  logic [BitCntW-1:0]              total;
  logic [ValueW+ByteW-1:0]         acc;
  logic [2:0]                      nbytes;
  mode_e                           mode;

  assign mode = mode_e'(mode_i);

  // Left-justify the new bits and count them
  always_comb begin
    bits_lj = '0;
    nbits   = '0;
    unique case (mode)
      ModeBit: begin
        bits_lj = {value_i[0], {(ValueW-1){1'b0}}};
        nbits   = BitCntW'(1);
      end
      ModeSymbol: begin
        bits_lj = {value_i[ByteW-1:0], {(ValueW-ByteW){1'b0}}};
        nbits   = BitCntW'(ByteW);
      end
      ModeNumber: begin
        bits_lj = value_i;
        nbits   = BitCntW'(ValueW);
      end
      ModeFlush: begin
        bits_lj = '0;
        nbits   = '0;
      end
      default: begin
        bits_lj = '0;
        nbits   = '0;
      end
    endcase
  end

  // Append behind the pending bits; bits past the total stay zero
  assign acc    = {partial_q, {ValueW{1'b0}}} | ({bits_lj, {ByteW{1'b0}}} >> pend_q);
  assign total  = BitCntW'(pend_q) + nbits;
  assign nbytes = total[BitCntW-1:PendW];

  // Job and next state
  always_comb begin
    job_o.bytes[0] = acc[39:32];
    job_o.bytes[1] = acc[31:24];
    job_o.bytes[2] = acc[23:16];
    job_o.bytes[3] = acc[15:8];
    job_o.last_idx = ByteIdxW'(nbytes - 3'd1);
    push_o         = accept_i && (nbytes != 3'd0);
    pend_d         = total[PendW-1:0];
    unique case (nbytes)
      3'd0:    partial_d = acc[39:32];
      3'd1:    partial_d = acc[31:24];
      3'd2:    partial_d = acc[23:16];
      3'd3:    partial_d = acc[15:8];
      3'd4:    partial_d = acc[7:0];
      default: partial_d = '0;
    endcase
    if (mode == ModeFlush) begin
      job_o.bytes[0] = partial_q;
      job_o.last_idx = '0;
      push_o         = accept_i && (pend_q != '0);
      pend_d         = '0;
      partial_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      pend_q    <= '0;
    end else if (accept_i) begin
      partial_q <= partial_d;
      pend_q    <= pend_d;
    end
  end

endmodule

[rtl/msbp_queue.sv]
module msbp_queue
  import msbp_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  job_t  job_i,
  output logic  full_o,
  output logic  valid_o,
  output job_t  job_o,
  input  logic  pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            store_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign job_o   = store_q[rd_ptr_q];

  // Job storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= job_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("job queue popped while empty");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth)) else $error("job queue count out of range");

endmodule

[rtl/msbp_back.sv]
module msbp_back
  import msbp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  job_t              job_i,
  output logic              pop_o,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [ByteW-1:0]  m_axis_tdata_o,
  output logic              m_axis_tlast_o
);

  logic [ByteIdxW-1:0] idx_q;
  logic                valid_q;
  logic [ByteW-1:0]    data_q;
  logic                last_q;
  logic                load;
  logic                at_last;

  // Output register refills when empty or being taken
  assign load    = job_valid_i && (!valid_q || m_axis_tready_i);
  assign at_last = (idx_q == job_i.last_idx);
  assign pop_o   = load && at_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q <= at_last ? '0 : idx_q + 1'b1;
      end
      if (load) begin
        valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Output word payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= job_i.bytes[idx_q];
      last_q <= at_last;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tlast_o  = last_q;

  a_idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i |-> idx_q <= job_i.last_idx) else $error("byte index past job end");

  a_no_load_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !m_axis_tready_i) |-> !pop_o) else $error("job retired under stall");

endmodule

[sim/msbp_checker.sv]
module msbp_checker
  import msbp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [ValueW-1:0] in_data_i,    // [31:0] value
  input  logic [1:0]        in_user_i,    // [1:0] mode
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [ByteW-1:0]  out_data_i,   // [7:0] out_byte
  input  logic              out_last_i,
  output int                fail_cnt_o,
  output int                pending_o,
  output int                bytes_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } packed_byte_t;

  // Bytes still owed by the block, oldest first
  packed_byte_t     owed_bytes_q[$];

  // Own copy of the packer state
  logic [ByteW-1:0] partial_byte = '0;
  logic [PendW-1:0] pend_bits    = '0;

  int mismatches = 0;
  int bytes_seen = 0;

  task automatic report_mismatch(input string what);
    $display("[%0t ns] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Appends the item's bits MSB first and queues every byte it completes
  task automatic pack_item(input mode_e mode, input logic [ValueW-1:0] value);
    logic [ValueW-1:0] bits;
    int                nbits;
    logic [ByteW-1:0]  done_q[$];
    bits  = value;
    nbits = 0;
    case (mode)
      ModeBit: begin
        bits  = ValueW'(value[0]);
        nbits = 1;
      end
      ModeSymbol: begin
        bits  = ValueW'(value[ByteW-1:0]);
        nbits = ByteW;
      end
      ModeNumber: begin
        nbits = ValueW;
      end
      default: begin
        // flush: partial byte goes out only if something is pending
        if (pend_bits != '0) done_q.push_back(partial_byte);
        partial_byte = '0;
        pend_bits    = '0;
      end
    endcase
    for (int k = nbits - 1; k >= 0; k--) begin
      partial_byte[ByteW-1-pend_bits] = bits[k];
      if (pend_bits == PendW'(ByteW - 1)) begin
        done_q.push_back(partial_byte);
        partial_byte = '0;
        pend_bits    = '0;
      end else begin
        pend_bits++;
      end
    end
    foreach (done_q[i])
      owed_bytes_q.push_back('{data: done_q[i], last: (i == done_q.size() - 1)});
  endtask

  // Predict on accepted items, compare on accepted bytes
  always @(posedge clk_i or negedge rst_ni) begin : watch
    packed_byte_t want;
    if (!rst_ni) begin
      owed_bytes_q.delete();
      partial_byte = '0;
      pend_bits    = '0;
    end else begin
      if (in_valid_i && in_ready_i) pack_item(mode_e'(in_user_i), in_data_i);
      if (out_valid_i && out_ready_i) begin
        bytes_seen++;
        if (owed_bytes_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last %0b", out_data_i, out_last_i));
        end else begin
          want = owed_bytes_q.pop_front();
          if (out_data_i !== want.data)
            report_mismatch($sformatf("byte %0d: data %02h, want %02h",
                                      bytes_seen, out_data_i, want.data));
          if (out_last_i !== want.last)
            report_mismatch($sformatf("byte %0d: last %0b, want %0b",
                                      bytes_seen, out_last_i, want.last));
        end
      end
    end
    pending_o  <= owed_bytes_q.size();
    fail_cnt_o <= mismatches;
    bytes_o    <= bytes_seen;
  end

endmodule

[sim/tb.sv]
module tb;
  import msbp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallMax  = 18;
  localparam int IdleLimit = 1000;
  localparam int PhaseLen  = 22;
  localparam int TailWait  = 20;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [ValueW-1:0] s_axis_tdata_i  = '0;    // [31:0] value
  logic [1:0]        s_axis_tuser_i  = ModeBit; // [1:0] mode
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [ByteW-1:0]  m_axis_tdata_o;          // [7:0] out_byte
  logic              m_axis_tlast_o;

  int fail_cnt;
  int bytes_owed;
  int bytes_done;
  int idle_cycles = 0;
  int send_gap_max = StallMax;
  int recv_stall_max = StallMax;
  int mode_cnt[4] = '{default: 0};

  msb_first_bit_packer DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  msbp_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_i (s_axis_tready_o),
    .in_data_i  (s_axis_tdata_i),
    .in_user_i  (s_axis_tuser_i),
    .out_valid_i(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_data_i (m_axis_tdata_o),
    .out_last_i (m_axis_tlast_o),
    .fail_cnt_o (fail_cnt),
    .pending_o  (bytes_owed),
    .bytes_o    (bytes_done)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: ends the run after too many cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("timeout: no word moved for %0d cycles", idle_cycles);
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver: random stall before each byte
  initial begin
    int stall;
    @(posedge clk_i iff rst_ni);
    forever begin
      stall = $urandom_range(0, recv_stall_max);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  // Sends one word after a random gap, returns once it is accepted
  task automatic send_word(input mode_e mode, input logic [ValueW-1:0] value);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= value;
    s_axis_tuser_i  <= mode;
    do @(posedge clk_i); while (!s_axis_tready_o);
    mode_cnt[mode]++;
  endtask

  // Holds the sender until every owed byte has come out
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (bytes_owed != 0);
  endtask

  function automatic logic [ValueW-1:0] draw_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic mode_e draw_mode();
    int r;
    r = $urandom_range(0, 19);
    if (r < 8)  return ModeBit;
    if (r < 13) return ModeSymbol;
    if (r < 18) return ModeNumber;
    return ModeFlush;
  endfunction

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: masking of wide values, flush cases, worst-case number
    send_word(ModeFlush, 32'hFFFF_FFFF);    // nothing pending: no byte
    send_word(ModeBit, 32'hFFFF_FFFE);      // only bit 0 counts
    send_word(ModeBit, 32'hFFFF_FFFF);
    send_word(ModeBit, 32'h0000_0001);
    send_word(ModeFlush, 32'h0000_0000);    // partial byte, zero low bits
    send_word(ModeFlush, 32'h0000_0000);    // second flush gives nothing
    send_word(ModeSymbol, 32'hFFFF_FF00);   // upper bits ignored
    send_word(ModeSymbol, 32'h0000_00FF);
    send_word(ModeSymbol, 32'h5A5A_5AA5);
    send_word(ModeNumber, 32'h0000_0000);
    send_word(ModeNumber, 32'hFFFF_FFFF);
    send_word(ModeNumber, 32'h8000_0001);
    for (int i = 0; i < 7; i++) send_word(ModeBit, 32'(i & 1));
    send_word(ModeNumber, 32'hDEAD_BEEF);   // seven pending: four bytes
    send_word(ModeSymbol, 32'hFFFF_FF3C);
    send_word(ModeBit, 32'h0000_0001);
    send_word(ModeFlush, 32'h1234_5678);
    wait_drained();

    // Random phases with different gap and stall profiles
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_gap_max = StallMax; recv_stall_max = StallMax; end
        1: begin send_gap_max = 0;        recv_stall_max = 0;        end
        2: begin send_gap_max = 0;        recv_stall_max = StallMax; end
        default: begin send_gap_max = StallMax; recv_stall_max = 0; end
      endcase
      for (int i = 0; i < PhaseLen; i++) send_word(draw_mode(), draw_value());
      wait_drained();
    end
    send_word(ModeFlush, '0);
    wait_drained();

    repeat (TailWait) @(posedge clk_i);
    $display("Sent %0d bit, %0d symbol, %0d number and %0d flush words; %0d bytes checked.",
             mode_cnt[ModeBit], mode_cnt[ModeSymbol], mode_cnt[ModeNumber],
             mode_cnt[ModeFlush], bytes_done);
    $display("Ran with full stalls, no stalls, and one-sided stalls on each side.");
    if (fail_cnt == 0 && bytes_owed == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
